/* rtl/keyed_deque_list_engine_defines.svh */
// Assertion macros shared by the list engine modules.
`ifndef KEYED_DEQUE_LIST_ENGINE_DEFINES_SVH
`define KEYED_DEQUE_LIST_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KDL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KDL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kdl_pkg.sv */
package kdl_pkg;

  // Field widths.
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned TOTAL_W    = 7;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - ST_W - KEY_W - TOTAL_W;

  // Default list capacity.
  localparam int unsigned CAPACITY_DEF = 64;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEL_KEY   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_FIRST = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_LAST  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DUMP      = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [ST_W-1:0] STATUS_NONE = 2'd1;
  localparam logic [ST_W-1:0] STATUS_FULL = 2'd2;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_START_HEAD,
    CMD_START_TAIL,
    CMD_START_FREE,
    CMD_ALLOC,
    CMD_STEP,
    CMD_UNLINK,
    CMD_FREE,
    CMD_EMIT_STATUS,
    CMD_EMIT_DUMP
  } dp_cmd_e;

  // Controller to datapath.
  typedef struct packed {
    dp_cmd_e         cmd;
    logic [ST_W-1:0] status;
  } dp_ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic at_end;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/keyed_deque_list_engine.sv */
// Keyed deque list engine: one request is processed at a time.
// Insert runs start, allocate and emit; delete-first and delete-last run start, unlink, free and emit.
// Delete by key walks from the head to the match before unlinking; dump gives one key a cycle while the output is free.
// The pointer walk over the link memory, one entry per cycle, bounds the busy time.
// Reset empties the list at once; slot memories need no clearing pass.
module keyed_deque_list_engine #(
  parameter int unsigned CAPACITY = kdl_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // key[31:0]
  input  logic [kdl_pkg::KEY_W-1:0]        s_axis_tdata,
  // action[2:0]
  input  logic [kdl_pkg::ACT_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[1:0], out_key[33:2], entry_total[40:34], zero[47:41]
  output logic [kdl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // has_key[0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  import kdl_pkg::*;

  dp_ctrl_t           ctrl;
  dp_stat_t           stat;
  logic [ST_W-1:0]    out_status;
  logic [KEY_W-1:0]   out_key;
  logic [TOTAL_W-1:0] out_total;

  // Sequencer.
  kdl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // List storage and output register.
  kdl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_i         (s_axis_tdata),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (out_status),
    .out_has_key_o (m_axis_tuser),
    .out_key_o     (out_key),
    .out_total_o   (out_total),
    .out_last_o    (m_axis_tlast)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_total, out_key, out_status};

endmodule

/* rtl/kdl_datapath.sv */
module kdl_datapath #(
  parameter int unsigned CAPACITY = kdl_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kdl_pkg::KEY_W-1:0]     key_i,
  input  kdl_pkg::dp_ctrl_t             ctrl_i,
  output kdl_pkg::dp_stat_t             stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [kdl_pkg::ST_W-1:0]      out_status_o,
  output logic                          out_has_key_o,
  output logic [kdl_pkg::KEY_W-1:0]     out_key_o,
  output logic [kdl_pkg::TOTAL_W-1:0]   out_total_o,
  output logic                          out_last_o
);
  import kdl_pkg::*;
  `include "keyed_deque_list_engine_defines.svh"

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Slot storage: key and both links per slot.
  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [AW-1:0]    nxt_mem [CAPACITY];
  logic [AW-1:0]    prv_mem [CAPACITY];

  logic [KEY_W-1:0] key_rd_q;
  logic [AW-1:0]    nxt_rd_q, prv_rd_q;

  logic [AW-1:0]    cur_d, cur_q, head_d, head_q, tail_d, tail_q, fhead_d, fhead_q;
  logic [CW-1:0]    idx_d, idx_q, count_d, count_q, fresh_d, fresh_q;
  logic [KEY_W-1:0] key_d, key_q;

  logic             key_we, nxt_we, prv_we;
  logic [AW-1:0]    key_wa, nxt_wa, prv_wa, nxt_wd, prv_wd;
  logic [KEY_W-1:0] key_wd;

  logic             out_load;
  logic [ST_W-1:0]  ld_status;
  logic             ld_has_key, ld_last;
  logic [KEY_W-1:0] ld_key;

  logic             out_valid_d, out_valid_q;
  logic [ST_W-1:0]  out_status_q;
  logic             out_has_key_q, out_last_q;
  logic [KEY_W-1:0] out_key_q;
  logic [TOTAL_W-1:0] out_total_q;

  logic             fresh_avail, at_end;
  logic [AW-1:0]    slot;

  // Never-used slots are handed out first, then recycled ones from the free chain.
  assign fresh_avail = (fresh_q != CW'(CAPACITY));
  assign slot        = fresh_avail ? fresh_q[AW-1:0] : cur_q;
  assign at_end      = ((idx_q + CW'(1)) == count_q);

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.match    = (key_rd_q == key_q);
  assign stat_o.at_end   = at_end;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Command decode: next pointers, memory writes and output loads.
  always_comb begin
    cur_d      = cur_q;
    idx_d      = idx_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    fresh_d    = fresh_q;
    fhead_d    = fhead_q;
    key_d      = key_q;
    key_we     = 1'b0;
    key_wa     = slot;
    key_wd     = key_q;
    nxt_we     = 1'b0;
    nxt_wa     = cur_q;
    nxt_wd     = head_q;
    prv_we     = 1'b0;
    prv_wa     = head_q;
    prv_wd     = slot;
    out_load   = 1'b0;
    ld_status  = ctrl_i.status;
    ld_has_key = 1'b0;
    ld_key     = '0;
    ld_last    = 1'b1;
    unique case (ctrl_i.cmd)
      CMD_START_HEAD: begin
        key_d = key_i;
        cur_d = head_q;
        idx_d = '0;
      end
      CMD_START_TAIL: begin
        key_d = key_i;
        cur_d = tail_q;
      end
      CMD_START_FREE: begin
        key_d = key_i;
        cur_d = fhead_q;
      end
      CMD_ALLOC: begin
        key_we  = 1'b1;
        nxt_we  = 1'b1;
        nxt_wa  = slot;
        nxt_wd  = head_q;
        if (count_q != '0) begin
          prv_we = 1'b1;
        end else begin
          tail_d = slot;
        end
        head_d  = slot;
        count_d = count_q + CW'(1);
        if (fresh_avail) begin
          fresh_d = fresh_q + CW'(1);
        end else begin
          fhead_d = nxt_rd_q;
        end
      end
      CMD_STEP: begin
        cur_d = nxt_rd_q;
        idx_d = idx_q + CW'(1);
      end
      CMD_UNLINK: begin
        // Bypass the current slot in both directions.
        if (cur_q == head_q) begin
          head_d = nxt_rd_q;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd_q;
          nxt_wd = nxt_rd_q;
        end
        if (cur_q == tail_q) begin
          tail_d = prv_rd_q;
        end else begin
          prv_we = 1'b1;
          prv_wa = nxt_rd_q;
          prv_wd = prv_rd_q;
        end
        count_d = count_q - CW'(1);
      end
      CMD_FREE: begin
        // Push the released slot onto the free chain.
        nxt_we  = 1'b1;
        nxt_wa  = cur_q;
        nxt_wd  = fhead_q;
        fhead_d = cur_q;
      end
      CMD_EMIT_STATUS: begin
        out_load = 1'b1;
      end
      CMD_EMIT_DUMP: begin
        out_load   = 1'b1;
        ld_status  = STATUS_OK;
        ld_has_key = 1'b1;
        ld_key     = key_rd_q;
        ld_last    = at_end;
        cur_d      = nxt_rd_q;
        idx_d      = idx_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // Memories: one write port each, read at the next current slot.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_q <= key_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    nxt_rd_q <= nxt_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    prv_rd_q <= prv_mem[cur_d];
  end

  // List bookkeeping registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      idx_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      fresh_q <= '0;
      fhead_q <= '0;
    end else begin
      cur_q   <= cur_d;
      idx_q   <= idx_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      fhead_q <= fhead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Output register: holds one result until the downstream side takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q  <= ld_status;
      out_has_key_q <= ld_has_key;
      out_key_q     <= ld_key;
      out_total_q   <= TOTAL_W'(count_q);
      out_last_q    <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_has_key_o = out_has_key_q;
  assign out_key_o     = out_key_q;
  assign out_total_o   = out_total_q;
  assign out_last_o    = out_last_q;

  // Every live entry occupies a slot that has been handed out at least once.
  `KDL_ASSERT_NOW(a_fresh_covers_count, clk_i, rst_ni, 1'b1, fresh_q >= count_q, "count exceeds used slots")
  // Allocation never runs on a full list.
  `KDL_ASSERT_NOW(a_alloc_not_full, clk_i, rst_ni, ctrl_i.cmd == CMD_ALLOC, count_q != CW'(CAPACITY), "alloc while full")
  // A result is never loaded over one that has not been taken.
  `KDL_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_load, !out_valid_q || out_ready_i, "output overwritten")

endmodule

/* rtl/kdl_ctrl.sv */
module kdl_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [kdl_pkg::ACT_W-1:0] action_i,
  input  kdl_pkg::dp_stat_t         stat_i,
  output kdl_pkg::dp_ctrl_t         ctrl_o
);
  import kdl_pkg::*;
  `include "keyed_deque_list_engine_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_UNL1 = 3'd3;
  localparam logic [2:0] S_UNL2 = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_DUMP = 3'd6;

  logic [2:0]      state_d, state_q;
  logic [ST_W-1:0] st_d, st_q;
  logic            accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Sequencer: one request at a time, each action a short command sequence.
  always_comb begin
    state_d       = state_q;
    st_d          = st_q;
    ctrl_o.cmd    = CMD_NOP;
    ctrl_o.status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_i)
            ACT_INSERT: begin
              if (stat_i.full) begin
                st_d    = STATUS_FULL;
                state_d = S_EMIT;
              end else begin
                ctrl_o.cmd = CMD_START_FREE;
                state_d    = S_INS;
              end
            end
            ACT_DEL_KEY: begin
              if (stat_i.empty) begin
                st_d    = STATUS_NONE;
                state_d = S_EMIT;
              end else begin
                ctrl_o.cmd = CMD_START_HEAD;
                state_d    = S_WALK;
              end
            end
            ACT_DEL_FIRST: begin
              if (stat_i.empty) begin
                st_d    = STATUS_NONE;
                state_d = S_EMIT;
              end else begin
                ctrl_o.cmd = CMD_START_HEAD;
                state_d    = S_UNL1;
              end
            end
            ACT_DEL_LAST: begin
              if (stat_i.empty) begin
                st_d    = STATUS_NONE;
                state_d = S_EMIT;
              end else begin
                ctrl_o.cmd = CMD_START_TAIL;
                state_d    = S_UNL1;
              end
            end
            ACT_DUMP: begin
              if (stat_i.empty) begin
                st_d    = STATUS_NONE;
                state_d = S_EMIT;
              end else begin
                ctrl_o.cmd = CMD_START_HEAD;
                state_d    = S_DUMP;
              end
            end
            default: begin
              // Unknown actions are dropped without a result.
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_INS: begin
        ctrl_o.cmd = CMD_ALLOC;
        st_d       = STATUS_OK;
        state_d    = S_EMIT;
      end
      S_WALK: begin
        if (stat_i.match) begin
          state_d = S_UNL1;
        end else if (stat_i.at_end) begin
          st_d    = STATUS_NONE;
          state_d = S_EMIT;
        end else begin
          ctrl_o.cmd = CMD_STEP;
        end
      end
      S_UNL1: begin
        ctrl_o.cmd = CMD_UNLINK;
        state_d    = S_UNL2;
      end
      S_UNL2: begin
        ctrl_o.cmd = CMD_FREE;
        st_d       = STATUS_OK;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = CMD_EMIT_STATUS;
          state_d    = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat_i.out_free) begin
          ctrl_o.cmd = CMD_EMIT_DUMP;
          if (stat_i.at_end) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= STATUS_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // Unlinking always finishes with the free-chain push.
  `KDL_ASSERT_NEXT(a_unlink_then_free, clk_i, rst_ni, state_q == S_UNL1, state_q == S_UNL2, "unlink sequence broken")
  // A dump walk only runs over a non-empty list.
  `KDL_ASSERT_NOW(a_dump_nonempty, clk_i, rst_ni, state_q == S_DUMP, !stat_i.empty, "dump of empty list")

endmodule
